FILE: hdl/csrspmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_pkg
// Shared widths, codes, types and fixed-point helpers for the sparse
// matrix-vector block with fused update and dot sums.
// ----------------------------------------------------------------------------
package csrspmv_pkg;

  localparam int VECTOR_DEPTH_DEF = 4096;

  localparam int IDX_W     = 12;
  localparam int VAL_W     = 32;
  localparam int ACC_W     = 48;
  localparam int DOT_W     = 64;
  localparam int PROD_W    = 64;
  localparam int WIDE_W    = 66;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 2;

  localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_FINISH  = 2'd2,
    OP_START   = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STORE = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_AXPBY = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESULT_MODE  = 3'd0,
    REG_SHIFT_ENABLE = 3'd1,
    REG_SCALE_ENABLE = 3'd2,
    REG_DOT_ENABLE   = 3'd3,
    REG_SCALE_FACTOR = 3'd4,
    REG_BETA_FACTOR  = 3'd5,
    REG_SHIFT_VALUE  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0]       result_mode;
    logic                    shift_enable;
    logic                    scale_enable;
    logic                    dot_enable;
    logic signed [VAL_W-1:0] scale_factor;
    logic signed [VAL_W-1:0] beta_factor;
    logic signed [VAL_W-1:0] shift_value;
  } cfg_t;

  typedef struct packed {
    logic                    wr;
    logic                    rd;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] wdata;
  } vmem_req_t;

  // round a Q.32 product to Q.16: floor((p + 2^15) / 2^16)
  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + 64'sd32768;
    return s[PROD_W-1:16];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:ACC_W-1] == {(WIDE_W-ACC_W+1){v[WIDE_W-1]}}) begin
      return v[ACC_W-1:0];
    end
    return v[WIDE_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:VAL_W-1] == {(ACC_W-VAL_W+1){v[ACC_W-1]}}) begin
      return v[VAL_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  function automatic logic signed [DOT_W-1:0] sat_add64(input logic signed [DOT_W-1:0] a,
                                                        input logic signed [DOT_W-1:0] b);
    logic signed [DOT_W-1:0] s;
    s = a + b;
    if ((a[DOT_W-1] == b[DOT_W-1]) && (s[DOT_W-1] != a[DOT_W-1])) begin
      return a[DOT_W-1] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

FILE: hdl/csrspmv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface csrspmv_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [1:0]                               operation;
  logic [csrspmv_pkg::IDX_W-1:0]            index;
  logic signed [csrspmv_pkg::VAL_W-1:0]     value;

  modport source (output valid, operation, index, value, input ready);
  modport sink   (input valid, operation, index, value, output ready);
endinterface

interface csrspmv_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [csrspmv_pkg::IDX_W-1:0]            row_index;
  logic signed [csrspmv_pkg::VAL_W-1:0]     result_value;
  logic signed [csrspmv_pkg::DOT_W-1:0]     dot_result_result;
  logic signed [csrspmv_pkg::DOT_W-1:0]     dot_result_vector;
  logic signed [csrspmv_pkg::DOT_W-1:0]     dot_vector_vector;

  modport source (output valid, row_index, result_value, dot_result_result,
                  dot_result_vector, dot_vector_vector, input ready);
  modport sink   (input valid, row_index, result_value, dot_result_result,
                  dot_result_vector, dot_vector_vector, output ready);
endinterface

interface csrspmv_cfg_if;
  logic                                     valid;
  logic                                     ready;
  logic [csrspmv_pkg::CFG_IDX_W-1:0]        index;
  logic [csrspmv_pkg::VAL_W-1:0]            data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/csrspmv_vmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_vmem
// Vector store: single-port synchronous memory with registered read data,
// indexes beyond the depth are dropped on write and read as zero.
// ----------------------------------------------------------------------------
module csrspmv_vmem #(
  parameter int DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                                 clk,
  input  csrspmv_pkg::vmem_req_t               req,
  output logic signed [csrspmv_pkg::VAL_W-1:0] rd_data
);
  import csrspmv_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic [31:0]             idx_w;
  logic [AW-1:0]           addr;
  logic                    in_range;
  logic signed [VAL_W-1:0] rd_q_r;
  logic                    in_range_r;

  assign idx_w    = 32'(req.idx);
  assign in_range = idx_w < 32'(DEPTH);
  assign addr     = idx_w[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr && in_range) begin
      mem[addr] <= req.wdata;
    end
    if (req.rd) begin
      rd_q_r     <= mem[addr];
      in_range_r <= in_range;
    end
  end

  assign rd_data = in_range_r ? rd_q_r : '0;

endmodule

FILE: hdl/csrspmv_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrspmv_engine
// Item sequencer and datapath: drives the vector store, accumulates
// nonzeros and runs the finish-row chain on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module csrspmv_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  csrspmv_in_if.sink                           in_ch,
  csrspmv_out_if.source                        out_ch,
  input  csrspmv_pkg::cfg_t                    cfg,
  output csrspmv_pkg::vmem_req_t               vreq,
  input  logic signed [csrspmv_pkg::VAL_W-1:0] vrd_data
);
  import csrspmv_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_NZ_MUL = 14'b00000000000010,
    ST_NZ_ACC = 14'b00000000000100,
    ST_FX     = 14'b00000000001000,
    ST_SHIFT  = 14'b00000000010000,
    ST_SC_HI  = 14'b00000000100000,
    ST_SC_LO  = 14'b00000001000000,
    ST_SC_ADD = 14'b00000010000000,
    ST_MODE   = 14'b00000100000000,
    ST_YY     = 14'b00001000000000,
    ST_YX     = 14'b00010000000000,
    ST_XX     = 14'b00100000000000,
    ST_XX_ACC = 14'b01000000000000,
    ST_EMIT   = 14'b10000000000000
  } state_t;

  state_t                   state_r;
  logic                     in_acc;
  logic                     emit_go;
  logic signed [VAL_W-1:0]  val_r;
  logic signed [VAL_W-1:0]  x_r;
  logic signed [VAL_W-1:0]  y_r;
  logic signed [VAL_W-1:0]  y_c;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  t_r;
  logic signed [PROD_W-1:0] hi_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [VAL_W-1:0]  mul_a;
  logic signed [VAL_W-1:0]  mul_b;
  logic [IDX_W-1:0]         row_r;
  logic signed [DOT_W-1:0]  sum_yy_r;
  logic signed [DOT_W-1:0]  sum_yx_r;
  logic signed [DOT_W-1:0]  sum_xx_r;

  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r;
  logic signed [VAL_W-1:0]  out_y_r;
  logic signed [DOT_W-1:0]  out_yy_r;
  logic signed [DOT_W-1:0]  out_yx_r;
  logic signed [DOT_W-1:0]  out_xx_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign emit_go     = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // load writes at the transfer, nonzero and finish read at the transfer
  always_comb begin
    vreq.wr    = in_acc && (in_ch.operation == OP_LOAD);
    vreq.rd    = in_acc && ((in_ch.operation == OP_NONZERO) ||
                            (in_ch.operation == OP_FINISH));
    vreq.idx   = (in_ch.operation == OP_FINISH) ? row_r : in_ch.index;
    vreq.wdata = in_ch.value;
  end

  assign y_c = sat32(t_r);

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_NZ_MUL: begin mul_a = val_r;                    mul_b = vrd_data;         end
      ST_FX:     begin mul_a = cfg.shift_value;          mul_b = vrd_data;         end
      ST_SC_HI:  begin mul_a = t_r[ACC_W-1:16];          mul_b = cfg.scale_factor; end
      ST_SC_LO:  begin mul_a = {16'b0, t_r[15:0]};       mul_b = cfg.scale_factor; end
      ST_SC_ADD: begin mul_a = cfg.beta_factor;          mul_b = val_r;            end
      ST_YY:     begin mul_a = y_c;                      mul_b = y_c;              end
      ST_YX:     begin mul_a = y_r;                      mul_b = x_r;              end
      ST_XX:     begin mul_a = x_r;                      mul_b = x_r;              end
      default:   begin mul_a = '0;                       mul_b = '0;               end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      row_r       <= '0;
      sum_yy_r    <= '0;
      sum_yx_r    <= '0;
      sum_xx_r    <= '0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            val_r <= in_ch.value;
            case (in_ch.operation)
              OP_NONZERO: state_r <= ST_NZ_MUL;
              OP_FINISH:  state_r <= ST_FX;
              OP_START: begin
                row_r    <= '0;
                acc_r    <= '0;
                sum_yy_r <= '0;
                sum_yx_r <= '0;
                sum_xx_r <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_NZ_MUL: state_r <= ST_NZ_ACC;
        ST_NZ_ACC: begin
          acc_r   <= sat48(WIDE_W'(acc_r) + WIDE_W'(rnd16(prod_r)));
          state_r <= ST_IDLE;
        end
        ST_FX: begin
          x_r     <= vrd_data;
          state_r <= ST_SHIFT;
        end
        ST_SHIFT: begin
          t_r     <= cfg.shift_enable ? sat48(WIDE_W'(acc_r) - WIDE_W'(rnd16(prod_r)))
                                      : acc_r;
          state_r <= ST_SC_HI;
        end
        ST_SC_HI: state_r <= ST_SC_LO;
        ST_SC_LO: begin
          hi_r    <= prod_r;
          state_r <= ST_SC_ADD;
        end
        ST_SC_ADD: begin
          // wide scale: high half product plus rounded low half product
          if (cfg.scale_enable) begin
            t_r <= sat48(WIDE_W'(hi_r) + WIDE_W'(rnd16(prod_r)));
          end
          state_r <= ST_MODE;
        end
        ST_MODE: begin
          case (cfg.result_mode)
            MODE_ADD:   t_r <= sat48(WIDE_W'(t_r) + WIDE_W'(val_r));
            MODE_AXPBY: t_r <= sat48(WIDE_W'(t_r) + WIDE_W'(rnd16(prod_r)));
            default: ;
          endcase
          state_r <= ST_YY;
        end
        ST_YY: begin
          y_r     <= y_c;
          state_r <= ST_YX;
        end
        ST_YX: begin
          if (cfg.dot_enable) begin
            sum_yy_r <= sat_add64(sum_yy_r, prod_r);
          end
          state_r <= ST_XX;
        end
        ST_XX: begin
          if (cfg.dot_enable) begin
            sum_yx_r <= sat_add64(sum_yx_r, prod_r);
          end
          state_r <= ST_XX_ACC;
        end
        ST_XX_ACC: begin
          if (cfg.dot_enable) begin
            sum_xx_r <= sat_add64(sum_xx_r, prod_r);
          end
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          // waits here until the output register is free
          if (emit_go) begin
            out_row_r <= row_r;
            out_y_r   <= y_r;
            out_yy_r  <= sum_yy_r;
            out_yx_r  <= sum_yx_r;
            out_xx_r  <= sum_xx_r;
            acc_r     <= '0;
            row_r     <= row_r + IDX_W'(1);
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.row_index         = out_row_r;
  assign out_ch.result_value      = out_y_r;
  assign out_ch.dot_result_result = out_yy_r;
  assign out_ch.dot_result_vector = out_yx_r;
  assign out_ch.dot_vector_vector = out_xx_r;

endmodule

FILE: hdl/csr_spmv_fused_axpby_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_spmv_fused_axpby_dot
// Compressed-row sparse matrix times vector with fused shift, scale,
// axpy/axpby update and running dot sums, Q16.16 fixed point.
//
//   channel  dir  carries
//   -------  ---  ---------------------------------------------------------
//   in_ch    in   operation, index, value (load / nonzero / finish / start)
//   out_ch   out  row_index, result_value, three running dot sums
//   cfg_ch   in   register index and data, always ready
//
// Load and start complete at the transfer; a nonzero steps through store
// read, multiply and accumulate, and a finish row through the chain of
// seven products on the one shared multiplier. Synchronous active-low reset
// clears control, counters and sums; the vector store is not cleared. A result
// waits in the output register; only a finish row stalls behind it.
// ----------------------------------------------------------------------------
module csr_spmv_fused_axpby_dot #(
  parameter int VECTOR_DEPTH = csrspmv_pkg::VECTOR_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  csrspmv_in_if.sink    in_ch,
  csrspmv_out_if.source out_ch,
  csrspmv_cfg_if.sink   cfg_ch
);
  import csrspmv_pkg::*;

  cfg_t                    cfg_r;
  vmem_req_t               vreq;
  logic signed [VAL_W-1:0] vrd_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.result_mode  <= MODE_STORE;
      cfg_r.shift_enable <= 1'b0;
      cfg_r.scale_enable <= 1'b0;
      cfg_r.dot_enable   <= 1'b0;
      cfg_r.scale_factor <= ONE_Q16;
      cfg_r.beta_factor  <= ONE_Q16;
      cfg_r.shift_value  <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_RESULT_MODE:  cfg_r.result_mode  <= cfg_ch.data[MODE_W-1:0];
        REG_SHIFT_ENABLE: cfg_r.shift_enable <= cfg_ch.data[0];
        REG_SCALE_ENABLE: cfg_r.scale_enable <= cfg_ch.data[0];
        REG_DOT_ENABLE:   cfg_r.dot_enable   <= cfg_ch.data[0];
        REG_SCALE_FACTOR: cfg_r.scale_factor <= cfg_ch.data;
        REG_BETA_FACTOR:  cfg_r.beta_factor  <= cfg_ch.data;
        REG_SHIFT_VALUE:  cfg_r.shift_value  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  csrspmv_vmem #(
    .DEPTH (VECTOR_DEPTH)
  ) u_vmem (
    .clk     (clk),
    .req     (vreq),
    .rd_data (vrd_data)
  );

  csrspmv_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg      (cfg_r),
    .vreq     (vreq),
    .vrd_data (vrd_data)
  );

endmodule
